/* src/lnep_pkg.sv */
package lnep_pkg;

    localparam int MaxNameChars   = 255;
    localparam int CharW          = $clog2(MaxNameChars + 1);
    localparam int LenW           = CharW + 1;
    localparam int PosW           = (LenW > 8) ? LenW : 8;
    localparam int UnitsPerEntry  = 13;
    localparam int UnitIdxW       = $clog2(UnitsPerEntry + 1);
    localparam int ShortNameBytes = 11;
    localparam int PartialBytes   = 6;
    localparam int QueueDepth     = 2;
    localparam int QPtrW          = $clog2(QueueDepth);
    localparam int QCntW          = $clog2(QueueDepth + 1);

    localparam logic [7:0]  AttrLong        = 8'h0F;
    localparam int          LastMarkBit     = 6;
    localparam logic [15:0] UnitEmpty       = 16'h0000;
    localparam logic [15:0] UnitPad         = 16'hFFFF;
    localparam logic [6:0]  EntryLimitReset = 7'd21;

    localparam int OrderByte    = 0;
    localparam int AttrByte     = 11;
    localparam int CsumByte     = 13;

    localparam int UnitOffset [UnitsPerEntry] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

    typedef enum logic [2:0] {
        ST_PART_OK      = 3'd0,
        ST_COMPLETE     = 3'd1,
        ST_NO_LONG      = 3'd2,
        ST_NO_LAST      = 3'd3,
        ST_ORDER        = 3'd4,
        ST_INCONSISTENT = 3'd5,
        ST_MISMATCH     = 3'd6,
        ST_LIMIT        = 3'd7
    } status_t;

    typedef logic [255:0] entry_t;

    typedef struct packed {
        logic [UnitsPerEntry-1:0][7:0] chars;
        logic [UnitIdxW-1:0]           count;
        logic [7:0]                    top_pos;
        status_t                       status;
        logic [5:0]                    entry_count;
        logic [7:0]                    name_length;
    } job_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] name_char;
        logic [7:0] reverse_position;
        status_t    status;
        logic [5:0] entry_count;
        logic [7:0] name_length;
        logic       last;
    } result_t;

    function automatic logic [7:0] byte_at(input entry_t e, input int i);
        byte_at = e[8*i +: 8];
    endfunction

    // one rotate-right-then-add step of the short name checksum
    function automatic logic [7:0] csum_step(input logic [7:0] sum, input logic [7:0] b);
        csum_step = {sum[0], sum[7:1]} + b;
    endfunction

endpackage

/* src/lnep_front.sv */
module lnep_front
    import lnep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  entry_t      entry,
    input  logic        entry_limit_we,
    input  logic [6:0]  entry_limit_data,
    output logic        job_push,
    output job_t        job,
    input  logic        job_full
);

    logic        s0_valid_reg;
    entry_t      s0_entry_reg;
    logic [7:0]  s0_psum_reg;
    logic [7:0]  psum;

    logic [6:0]       limit_reg;
    logic             in_seq_reg, in_seq_next;
    logic [5:0]       exp_order_reg, exp_order_next;
    logic [7:0]       seq_csum_reg, seq_csum_next;
    logic [6:0]       entries_reg, entries_next;
    logic [CharW-1:0] chars_reg, chars_next;

    logic                         advance;
    logic [7:0]                   sum_full;
    logic [7:0]                   order, attr, csum;
    logic [UnitsPerEntry-1:0]     term;
    logic [UnitsPerEntry-1:0][15:0] units;
    logic [UnitIdxW-1:0]          cnt;
    logic [LenW-1:0]              chars_sum;
    logic [PosW-1:0]              top_full;
    logic [PosW-1:0]              len_full;
    logic                         ok, close;

    assign advance  = s0_valid_reg && !job_full;
    assign full     = s0_valid_reg && job_full;
    assign job_push = advance;

    // first part of the checksum while the entry is captured
    always_comb
    begin
        psum = '0;
        for (int i = 0; i < PartialBytes; i++)
        begin
            psum = csum_step(psum, byte_at(entry, i));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (!s0_valid_reg || advance)
        begin
            s0_valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            s0_entry_reg <= entry;
            s0_psum_reg  <= psum;
        end
    end

    always_comb
    begin
        sum_full = s0_psum_reg;
        for (int i = PartialBytes; i < ShortNameBytes; i++)
        begin
            sum_full = csum_step(sum_full, byte_at(s0_entry_reg, i));
        end
    end

    assign order = byte_at(s0_entry_reg, OrderByte);
    assign attr  = byte_at(s0_entry_reg, AttrByte);
    assign csum  = byte_at(s0_entry_reg, CsumByte);

    always_comb
    begin
        for (int i = 0; i < UnitsPerEntry; i++)
        begin
            units[i] = {byte_at(s0_entry_reg, UnitOffset[i] + 1),
                        byte_at(s0_entry_reg, UnitOffset[i])};
            term[i]  = (units[i] == UnitEmpty) || (units[i] == UnitPad);
        end
        // first terminator ends the name part
        cnt = UnitIdxW'(UnitsPerEntry);
        for (int i = UnitsPerEntry - 1; i >= 0; i--)
        begin
            if (term[i])
            begin
                cnt = UnitIdxW'(i);
            end
        end
    end

    assign chars_sum = LenW'(chars_reg) + LenW'(cnt);
    assign top_full  = PosW'(chars_reg) + PosW'(cnt) - PosW'(1);

    always_comb
    begin
        in_seq_next    = in_seq_reg;
        exp_order_next = exp_order_reg;
        seq_csum_next  = seq_csum_reg;
        entries_next   = entries_reg;
        chars_next     = chars_reg;
        ok             = 1'b0;
        close          = 1'b0;

        for (int i = 0; i < UnitsPerEntry; i++)
        begin
            job.chars[i] = units[i][7:0];
        end
        job.count  = '0;
        job.top_pos = top_full[7:0];
        job.status = ST_PART_OK;

        if (entries_reg >= limit_reg)
        begin
            job.status = ST_LIMIT;
            close      = 1'b1;
        end
        else if (attr != AttrLong)
        begin
            if (!in_seq_reg)
            begin
                job.status = ST_NO_LONG;
            end
            else if (exp_order_reg != '0)
            begin
                job.status = ST_ORDER;
                close      = 1'b1;
            end
            else
            begin
                job.status = (sum_full == seq_csum_reg) ? ST_COMPLETE : ST_MISMATCH;
                close      = 1'b1;
            end
        end
        else if (!in_seq_reg && !order[LastMarkBit])
        begin
            job.status = ST_NO_LAST;
            close      = 1'b1;
        end
        else if (!in_seq_reg && order[5:0] == '0)
        begin
            job.status = ST_ORDER;
            close      = 1'b1;
        end
        else if (in_seq_reg && (exp_order_reg == '0 || order != {2'b00, exp_order_reg}))
        begin
            job.status = ST_ORDER;
            close      = 1'b1;
        end
        else if (in_seq_reg && csum != seq_csum_reg)
        begin
            job.status = ST_INCONSISTENT;
            close      = 1'b1;
        end
        else if (chars_sum > LenW'(MaxNameChars))
        begin
            job.status = ST_LIMIT;
            close      = 1'b1;
        end
        else
        begin
            ok = 1'b1;
        end

        if (ok)
        begin
            job.count    = cnt;
            entries_next = entries_reg + 7'd1;
            chars_next   = chars_sum[CharW-1:0];
            if (!in_seq_reg)
            begin
                in_seq_next    = 1'b1;
                exp_order_next = order[5:0] - 6'd1;
                seq_csum_next  = csum;
            end
            else
            begin
                exp_order_next = exp_order_reg - 6'd1;
            end
        end

        // status carries counts after a good part, before a failing one
        job.entry_count = ok ? entries_next[5:0] : entries_reg[5:0];
        len_full        = ok ? PosW'(chars_next) : PosW'(chars_reg);
        job.name_length = len_full[7:0];

        if (close)
        begin
            in_seq_next    = 1'b0;
            exp_order_next = '0;
            seq_csum_next  = '0;
            entries_next   = '0;
            chars_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= EntryLimitReset;
            in_seq_reg    <= 1'b0;
            exp_order_reg <= '0;
            seq_csum_reg  <= '0;
            entries_reg   <= '0;
            chars_reg     <= '0;
        end
        else
        begin
            if (entry_limit_we)
            begin
                limit_reg <= entry_limit_data;
            end
            if (advance)
            begin
                in_seq_reg    <= in_seq_next;
                exp_order_reg <= exp_order_next;
                seq_csum_reg  <= seq_csum_next;
                entries_reg   <= entries_next;
                chars_reg     <= chars_next;
            end
        end
    end

    a_idle_counts_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_seq_reg |-> (entries_reg == '0 && chars_reg == '0))
        else $error("counts left over outside a sequence");

    a_stalled_entry_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_valid_reg && job_full) |=> s0_valid_reg)
        else $error("captured entry dropped while the job queue was full");

endmodule

/* src/lnep_queue.sv */
module lnep_queue
    import lnep_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic q_full,
    input  logic rd_en,
    output job_t rd_job,
    output logic q_empty
);

    job_t             slot_reg [QueueDepth];
    logic [QPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCntW-1:0] count_reg;
    logic             do_wr, do_rd;

    assign q_full  = (count_reg == QCntW'(QueueDepth));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCntW'(QueueDepth))
        else $error("job queue count out of range");

endmodule

/* src/lnep_back.sv */
module lnep_back
    import lnep_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  job_t    q_job,
    input  logic    q_empty,
    output logic    q_pop,
    output result_t res,
    output logic    empty,
    input  logic    pop
);

    logic                cur_valid_reg;
    job_t                cur_job_reg;
    logic [UnitIdxW-1:0] idx_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                load_out, emit_char, finishing;
    result_t             out_next;

    assign load_out  = !out_valid_reg || pop;
    assign emit_char = idx_reg < cur_job_reg.count;
    assign finishing = cur_valid_reg && load_out && !emit_char;
    assign q_pop     = !q_empty && (!cur_valid_reg || finishing);

    always_comb
    begin
        out_next = '0;
        if (emit_char)
        begin
            out_next.name_char        = cur_job_reg.chars[idx_reg];
            out_next.reverse_position = cur_job_reg.top_pos - 8'(idx_reg);
            out_next.status           = ST_PART_OK;
        end
        else
        begin
            out_next.is_status   = 1'b1;
            out_next.status      = cur_job_reg.status;
            out_next.entry_count = cur_job_reg.entry_count;
            out_next.name_length = cur_job_reg.name_length;
            out_next.last        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (finishing)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (cur_valid_reg && load_out)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= cur_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_job_reg <= q_job;
        end
        if (cur_valid_reg && load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign res   = out_reg;
    assign empty = !out_valid_reg;

    a_last_on_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.last == out_reg.is_status))
        else $error("last flag not tied to the status result");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg <= cur_job_reg.count))
        else $error("character index ran past the job");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting result changed before transfer");

endmodule

/* src/long_name_entry_parser_core.sv */
// long-name directory entry parser
// input side is a queue: an entry (four 64-bit words, byte 0 in entry_word_0[7:0])
// transfers on a clock edge with push high and full low.
// result side is a queue: the oldest result sits on the result ports while empty
// is low and transfers on an edge with pop high.
// each entry yields its name characters if accepted (low byte and position from
// the name end), then one status result with last set; so 1 to 14 results per entry.
// entries pass the capture stage, job queue and current job register in turn.
// an entry can be taken every cycle while the job queue has room; the result side
// moves one result per cycle while pop is held high.
// a two-entry job queue between the classifier and the result serializer absorbs
// bursts; full rises only when that queue and the capture stage are both taken.
// stalling pop holds the current result and backs up through the queue to full.
// entry_limit is written with entry_limit_we; reset loads 21 and closes any
// open sequence, with no results pending.
module long_name_entry_parser_core
    import lnep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] entry_word_0,
    input  logic [63:0] entry_word_1,
    input  logic [63:0] entry_word_2,
    input  logic [63:0] entry_word_3,
    input  logic        entry_limit_we,
    input  logic [6:0]  entry_limit_data,
    output logic        empty,
    input  logic        pop,
    output logic        is_status,
    output logic [7:0]  name_char,
    output logic [7:0]  reverse_position,
    output logic [2:0]  status,
    output logic [5:0]  entry_count,
    output logic [7:0]  name_length,
    output logic        last
);

    entry_t  entry;
    job_t    front_job, q_job;
    logic    job_push, job_full, q_empty, q_pop;
    result_t res;

    assign entry = {entry_word_3, entry_word_2, entry_word_1, entry_word_0};

    lnep_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .entry            (entry),
        .entry_limit_we   (entry_limit_we),
        .entry_limit_data (entry_limit_data),
        .job_push         (job_push),
        .job              (front_job),
        .job_full         (job_full)
    );

    lnep_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (front_job),
        .q_full  (job_full),
        .rd_en   (q_pop),
        .rd_job  (q_job),
        .q_empty (q_empty)
    );

    lnep_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_job   (q_job),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .res     (res),
        .empty   (empty),
        .pop     (pop)
    );

    assign is_status        = res.is_status;
    assign name_char        = res.name_char;
    assign reverse_position = res.reverse_position;
    assign status           = res.status;
    assign entry_count      = res.entry_count;
    assign name_length      = res.name_length;
    assign last             = res.last;

endmodule
